// File: rtl/opq_pkg.sv
// shared types, codes and sizing for the ordered priority queue
package opq_pkg;

    // number of slots held in the queue
    localparam int CAPACITY = 16;
    // width of the entry counter, able to hold CAPACITY itself
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // width of the reported occupancy field
    localparam int OCC_W    = 5;

    // operation codes
    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_DELETE   = 3'd2;
    localparam logic [2:0] OP_CONTAINS = 3'd3;
    localparam logic [2:0] OP_PEEK     = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    // one stored entry
    typedef struct packed {
        logic [31:0] tag;
        logic [15:0] pri;
        logic [31:0] seq;
    } slot_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } opq_cmd_t;

endpackage

// File: rtl/opq_ctrl.sv
// controller: sequences capture, compare and update, owns the result valid flag
module opq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output opq_pkg::opq_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   upd_fire;

    // handshake and commands
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = out_valid_reg;
    assign upd_fire    = (state_reg == ST_UPD) && (!out_valid_reg || m_ready);
    assign cmd.load    = s_valid && s_ready;
    assign cmd.compare = (state_reg == ST_CMP);
    assign cmd.update  = upd_fire;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (upd_fire) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (upd_fire) begin
            out_valid_next = 1'b1;
        end else if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // update never overwrites a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!out_valid_reg || m_ready))
        else $error("update while result register busy");

    // an accepted transaction goes straight to the compare step
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_CMP))
        else $error("accept not followed by compare");

    // a new result appears only from an update
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.update))
        else $error("result valid without update");

endmodule

// File: rtl/opq_datapath.sv
// datapath: slot array, parallel compare, shift update and result register
module opq_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  opq_pkg::opq_cmd_t        cmd,
    input  logic [2:0]               s_op,
    input  logic [31:0]              s_item_tag,
    input  logic [15:0]              s_item_priority,
    input  logic [31:0]              s_item_seq,
    output logic [1:0]               m_status,
    output logic                     m_found,
    output logic                     m_entry_valid,
    output logic [31:0]              m_entry_tag,
    output logic [15:0]              m_entry_priority,
    output logic [31:0]              m_entry_seq,
    output logic [opq_pkg::OCC_W-1:0] m_occupancy
);

    // slot storage and captured transaction
    opq_pkg::slot_t                 slot_reg  [opq_pkg::CAPACITY];
    opq_pkg::slot_t                 slot_next [opq_pkg::CAPACITY];
    opq_pkg::slot_t                 ins_slot  [opq_pkg::CAPACITY];
    opq_pkg::slot_t                 rem_slot  [opq_pkg::CAPACITY];
    opq_pkg::slot_t                 del_slot  [opq_pkg::CAPACITY];
    opq_pkg::slot_t                 item_reg;
    logic [2:0]                     op_reg;
    logic [opq_pkg::CAPACITY-1:0]   ge_reg;
    logic [opq_pkg::CAPACITY-1:0]   match_reg;
    logic [opq_pkg::CAPACITY-1:0]   after_match;
    logic [opq_pkg::CAPACITY-1:0]   used_reg, used_next;
    logic [opq_pkg::CNT_W-1:0]      count_reg, count_next;

    // result fields
    logic [1:0]     status;
    logic           found;
    logic           take_valid;
    logic           show_head;
    logic           res_valid;
    opq_pkg::slot_t res_entry;
    logic           empty;
    logic           full;

    // capture the transaction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_op;
            item_reg.tag <= s_item_tag;
            item_reg.pri <= s_item_priority;
            item_reg.seq <= s_item_seq;
        end
    end

    // per-slot compare against the captured item
    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            for (int i = 0; i < opq_pkg::CAPACITY; i++) begin
                ge_reg[i]    <= used_reg[i] && (slot_reg[i].pri >= item_reg.pri);
                match_reg[i] <= used_reg[i] && (slot_reg[i] == item_reg);
            end
        end
    end

    // per-slot candidates for insert, remove head and delete
    for (genvar i = 0; i < opq_pkg::CAPACITY; i++) begin : g_slot
        opq_pkg::slot_t lower;
        opq_pkg::slot_t upper;
        logic           prev_ge;

        if (i == 0) begin : g_first
            assign lower   = slot_reg[i];
            assign prev_ge = 1'b1;
        end else begin : g_rest
            assign lower   = slot_reg[i-1];
            assign prev_ge = ge_reg[i-1];
        end

        if (i == opq_pkg::CAPACITY - 1) begin : g_last
            assign upper = slot_reg[i];
        end else begin : g_inner
            assign upper = slot_reg[i+1];
        end

        // at or past the first match
        assign after_match[i] = |match_reg[i:0];

        assign ins_slot[i] = ge_reg[i] ? slot_reg[i] : (prev_ge ? item_reg : lower);
        assign rem_slot[i] = upper;
        assign del_slot[i] = after_match[i] ? upper : slot_reg[i];
    end

    assign empty = (count_reg == '0);
    assign full  = (count_reg == opq_pkg::CNT_W'(opq_pkg::CAPACITY));

    // operation decode
    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        used_next  = used_reg;
        status     = opq_pkg::ST_OK;
        found      = 1'b0;
        take_valid = 1'b0;
        show_head  = 1'b1;
        unique case (op_reg)
            opq_pkg::OP_INSERT: begin
                if (full) begin
                    status = opq_pkg::ST_FULL;
                end else begin
                    slot_next  = ins_slot;
                    count_next = count_reg + 1'b1;
                    used_next  = (used_reg << 1) | opq_pkg::CAPACITY'(1);
                end
            end
            opq_pkg::OP_REMOVE: begin
                show_head = 1'b0;
                if (empty) begin
                    status = opq_pkg::ST_EMPTY;
                end else begin
                    take_valid = 1'b1;
                    slot_next  = rem_slot;
                    count_next = count_reg - 1'b1;
                    used_next  = used_reg >> 1;
                end
            end
            opq_pkg::OP_DELETE: begin
                if (empty) begin
                    status = opq_pkg::ST_EMPTY;
                end else if (|match_reg) begin
                    found      = 1'b1;
                    slot_next  = del_slot;
                    count_next = count_reg - 1'b1;
                    used_next  = used_reg >> 1;
                end else begin
                    status = opq_pkg::ST_NOMATCH;
                end
            end
            opq_pkg::OP_CONTAINS: begin
                if (empty) begin
                    status = opq_pkg::ST_EMPTY;
                end else begin
                    found = |match_reg;
                end
            end
            opq_pkg::OP_PEEK: begin
                if (empty) status = opq_pkg::ST_EMPTY;
            end
            opq_pkg::OP_CLEAR: begin
                show_head  = 1'b0;
                count_next = '0;
                used_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // reported entry: removed one on remove, none on clear, else head after the operation
    always_comb begin
        if (show_head) begin
            res_valid = (count_next != '0);
            res_entry = res_valid ? slot_next[0] : '0;
        end else begin
            res_valid = take_valid;
            res_entry = take_valid ? slot_reg[0] : '0;
        end
    end

    // slot contents
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            for (int i = 0; i < opq_pkg::CAPACITY; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    // occupancy state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            used_reg  <= '0;
        end else if (cmd.update) begin
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            m_status         <= status;
            m_found          <= found;
            m_entry_valid    <= res_valid;
            m_entry_tag      <= res_entry.tag;
            m_entry_priority <= res_entry.pri;
            m_entry_seq      <= res_entry.seq;
            m_occupancy      <= opq_pkg::OCC_W'(count_next);
        end
    end

    // used flags always track the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) == int'(count_reg))
        else $error("used flags disagree with count");

    // count never passes capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= opq_pkg::CAPACITY)
        else $error("count above capacity");

endmodule

// File: rtl/ordered_priority_queue_top.sv
// top level of the ordered priority queue
// latency: result valid once the accepted transaction has passed the compare step and then the update step
// a new transaction is taken only after the previous one has finished its capture, compare, update sequence
// the result register lets the next transaction be taken while a result waits
// reset: synchronous active low, empties the queue and drops any pending result
// slot contents are not cleared by reset; no clearing pass is needed
module ordered_priority_queue_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_op,
    input  logic [31:0]               s_item_tag,
    input  logic [15:0]               s_item_priority,
    input  logic [31:0]               s_item_seq,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic                      m_found,
    output logic                      m_entry_valid,
    output logic [31:0]               m_entry_tag,
    output logic [15:0]               m_entry_priority,
    output logic [31:0]               m_entry_seq,
    output logic [opq_pkg::OCC_W-1:0] m_occupancy
);

    opq_pkg::opq_cmd_t cmd;

    // sequencing
    opq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // storage and compute
    opq_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_op             (s_op),
        .s_item_tag       (s_item_tag),
        .s_item_priority  (s_item_priority),
        .s_item_seq       (s_item_seq),
        .m_status         (m_status),
        .m_found          (m_found),
        .m_entry_valid    (m_entry_valid),
        .m_entry_tag      (m_entry_tag),
        .m_entry_priority (m_entry_priority),
        .m_entry_seq      (m_entry_seq),
        .m_occupancy      (m_occupancy)
    );

endmodule

// File: bench/ordered_priority_queue_top_tb.sv
// testbench for the ordered priority queue: random and directed operations checked against a predictor
`timescale 1ns / 1ps

module ordered_priority_queue_top_tb;

    // codes the block treats as no operation
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;

    // one result transaction
    typedef struct packed {
        logic [1:0]                status;
        logic                      found;
        logic                      entry_valid;
        opq_pkg::slot_t            entry;
        logic [opq_pkg::OCC_W-1:0] occupancy;
    } result_t;

    // sorted queue model plus the results it still owes
    class opq_scoreboard;
        opq_pkg::slot_t slots [opq_pkg::CAPACITY];
        int unsigned    count;
        result_t        owed_results [$];
        int             mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        // close the gap left by slot pos
        function void take_out(int unsigned pos);
            for (int unsigned i = pos; i + 1 < count; i++)
                slots[i] = slots[i + 1];
            count--;
            slots[count] = '0;
        endfunction

        // first exact match, or count when there is none
        function int unsigned find_match(opq_pkg::slot_t probe);
            for (int unsigned i = 0; i < count; i++)
                if (slots[i] == probe)
                    return i;
            return count;
        endfunction

        // apply one accepted operation and queue the result it should give
        function void note_transaction(logic [2:0] op, opq_pkg::slot_t item);
            result_t     res;
            int unsigned pos;
            bit          show_head;
            res       = '0;
            show_head = 1'b1;
            case (op)
                opq_pkg::OP_INSERT: begin
                    if (count >= opq_pkg::CAPACITY) begin
                        res.status = opq_pkg::ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < count && slots[pos].pri >= item.pri)
                            pos++;
                        for (int unsigned i = count; i > pos; i--)
                            slots[i] = slots[i - 1];
                        slots[pos] = item;
                        count++;
                    end
                end
                opq_pkg::OP_REMOVE: begin
                    if (count == 0) begin
                        res.status = opq_pkg::ST_EMPTY;
                    end else begin
                        res.entry_valid = 1'b1;
                        res.entry       = slots[0];
                        take_out(0);
                    end
                    show_head = 1'b0;
                end
                opq_pkg::OP_DELETE: begin
                    if (count == 0) begin
                        res.status = opq_pkg::ST_EMPTY;
                    end else begin
                        pos = find_match(item);
                        if (pos < count) begin
                            res.found = 1'b1;
                            take_out(pos);
                        end else begin
                            res.status = opq_pkg::ST_NOMATCH;
                        end
                    end
                end
                opq_pkg::OP_CONTAINS: begin
                    if (count == 0)
                        res.status = opq_pkg::ST_EMPTY;
                    else if (find_match(item) < count)
                        res.found = 1'b1;
                end
                opq_pkg::OP_PEEK: begin
                    if (count == 0)
                        res.status = opq_pkg::ST_EMPTY;
                end
                opq_pkg::OP_CLEAR: begin
                    for (int unsigned i = 0; i < opq_pkg::CAPACITY; i++)
                        slots[i] = '0;
                    count     = 0;
                    show_head = 1'b0;
                end
                default: ;
            endcase
            // head after the operation
            if (show_head && count > 0) begin
                res.entry_valid = 1'b1;
                res.entry       = slots[0];
            end
            res.occupancy = count[opq_pkg::OCC_W-1:0];
            owed_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // compare a result with the oldest one owed
        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0) begin
                $error("result transaction with no operation outstanding");
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("found", want.found, got.found);
            compare_field("entry_valid", want.entry_valid, got.entry_valid);
            compare_field("entry_tag", want.entry.tag, got.entry.tag);
            compare_field("entry_priority", want.entry.pri, got.entry.pri);
            compare_field("entry_seq", want.entry.seq, got.entry.seq);
            compare_field("occupancy", want.occupancy, got.occupancy);
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [2:0]                s_op;
    logic [31:0]               s_item_tag;
    logic [15:0]               s_item_priority;
    logic [31:0]               s_item_seq;
    logic                      m_valid;
    logic                      m_ready;
    logic [1:0]                m_status;
    logic                      m_found;
    logic                      m_entry_valid;
    logic [31:0]               m_entry_tag;
    logic [15:0]               m_entry_priority;
    logic [31:0]               m_entry_seq;
    logic [opq_pkg::OCC_W-1:0] m_occupancy;

    opq_scoreboard sb;
    bit            sender_quiet;

    ordered_priority_queue_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_item_tag       (s_item_tag),
        .s_item_priority  (s_item_priority),
        .s_item_seq       (s_item_seq),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found          (m_found),
        .m_entry_valid    (m_entry_valid),
        .m_entry_tag      (m_entry_tag),
        .m_entry_priority (m_entry_priority),
        .m_entry_seq      (m_entry_seq),
        .m_occupancy      (m_occupancy)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic opq_pkg::slot_t make_slot(logic [31:0] tag, logic [15:0] pri,
                                                 logic [31:0] seq);
        opq_pkg::slot_t s;
        s.tag = tag;
        s.pri = pri;
        s.seq = seq;
        return s;
    endfunction

    // tight priority pools give plenty of ties
    function automatic logic [15:0] draw_priority();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 3));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one operation and wait until it is taken
    task automatic drive_transaction(input logic [2:0] op, input opq_pkg::slot_t item);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_op            <= op;
        s_item_tag      <= item.tag;
        s_item_priority <= item.pri;
        s_item_seq      <= item.seq;
        do @(posedge aclk); while (!s_ready);
        sb.note_transaction(op, item);
    endtask

    // random operation, weighted toward filling or draining the queue
    task automatic pick_random(input bit filling, output logic [2:0] op,
                               output opq_pkg::slot_t item);
        int          roll;
        int          ins_end;
        int          rem_end;
        int          del_end;
        int unsigned idx;
        int unsigned bit_pos;
        roll    = $urandom_range(0, 99);
        ins_end = filling ? 55 : 15;
        rem_end = filling ? 65 : 50;
        del_end = filling ? 75 : 70;
        if (roll < ins_end)
            op = opq_pkg::OP_INSERT;
        else if (roll < rem_end)
            op = opq_pkg::OP_REMOVE;
        else if (roll < del_end)
            op = opq_pkg::OP_DELETE;
        else if (roll < 85)
            op = opq_pkg::OP_CONTAINS;
        else if (roll < 94)
            op = opq_pkg::OP_PEEK;
        else if (roll < 95)
            op = opq_pkg::OP_CLEAR;
        else
            op = $urandom_range(0, 1) ? OP_UNUSED_LO : OP_UNUSED_HI;
        item = make_slot($urandom, draw_priority(), $urandom);
        // match targets mostly come from live entries, some with one bit off
        if ((op == opq_pkg::OP_DELETE || op == opq_pkg::OP_CONTAINS) && sb.count > 0
                && $urandom_range(0, 9) < 7) begin
            idx  = $urandom_range(0, sb.count - 1);
            item = sb.slots[idx];
            if ($urandom_range(0, 4) == 0) begin
                bit_pos = $urandom_range(0, 79);
                item[bit_pos] = ~item[bit_pos];
            end
        end
        // exact duplicates exercise first-match delete
        if (op == opq_pkg::OP_INSERT && sb.count > 0 && $urandom_range(0, 9) == 0) begin
            idx  = $urandom_range(0, sb.count - 1);
            item = sb.slots[idx];
        end
    endtask

    // result side: random stalls, one long hold-off, check every result
    initial begin
        int      gap;
        int      received;
        bit      quiet;
        bit      held;
        result_t got;
        m_ready  = 1'b0;
        received = 0;
        quiet    = 1'b0;
        held     = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (received % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, 16);
            if (!held && received == HOLD_AT) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.status      = m_status;
            got.found       = m_found;
            got.entry_valid = m_entry_valid;
            got.entry       = make_slot(m_entry_tag, m_entry_priority, m_entry_seq);
            got.occupancy   = m_occupancy;
            sb.check_result(got);
            received++;
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("FAIL");
        $finish;
    end

    // reset, directed operations, random operations, drain
    initial begin
        logic [2:0]     op;
        opq_pkg::slot_t item;
        int             phase_left;
        bit             filling;
        sb              = new();
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_op            = opq_pkg::OP_PEEK;
        s_item_tag      = '0;
        s_item_priority = '0;
        s_item_seq      = '0;
        sender_quiet    = 1'b0;
        phase_left      = 0;
        filling         = 1'b1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every read-type operation on an empty queue, then a clear and an unused code
        drive_transaction(opq_pkg::OP_PEEK, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(opq_pkg::OP_REMOVE, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(opq_pkg::OP_DELETE,
                          make_slot(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        drive_transaction(opq_pkg::OP_CONTAINS, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(opq_pkg::OP_CLEAR, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(OP_UNUSED_LO, make_slot(32'h0, 16'h0, 32'h0));
        // field extremes and equal priorities in arrival order
        drive_transaction(opq_pkg::OP_INSERT,
                          make_slot(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        drive_transaction(opq_pkg::OP_INSERT, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(opq_pkg::OP_INSERT, make_slot(32'hA5A5_0001, 16'h8000, 32'h1));
        drive_transaction(opq_pkg::OP_INSERT, make_slot(32'h5A5A_0002, 16'h8000, 32'h2));
        drive_transaction(opq_pkg::OP_INSERT, make_slot(32'hA5A5_0001, 16'h8000, 32'h1));
        // hit and near miss for contains and delete, then an unused code, removes, peeks and a clear
        drive_transaction(opq_pkg::OP_CONTAINS, make_slot(32'hA5A5_0001, 16'h8000, 32'h1));
        drive_transaction(opq_pkg::OP_CONTAINS, make_slot(32'hA5A5_0001, 16'h8000, 32'h2));
        drive_transaction(opq_pkg::OP_DELETE, make_slot(32'h0, 16'h0, 32'h1));
        drive_transaction(opq_pkg::OP_DELETE, make_slot(32'hA5A5_0001, 16'h8000, 32'h1));
        drive_transaction(OP_UNUSED_HI, make_slot(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
        drive_transaction(opq_pkg::OP_REMOVE, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(opq_pkg::OP_PEEK, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(opq_pkg::OP_REMOVE, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(opq_pkg::OP_CLEAR, make_slot(32'h0, 16'h0, 32'h0));
        drive_transaction(opq_pkg::OP_PEEK, make_slot(32'h0, 16'h0, 32'h0));

        // random phases alternate between filling and draining
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                filling      = $urandom_range(0, 1);
                phase_left   = $urandom_range(20, 60);
                sender_quiet = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            pick_random(filling, op, item);
            drive_transaction(op, item);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // wait out the outstanding results
        while (sb.owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.owed_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/opq_pkg.sv
rtl/opq_ctrl.sv
rtl/opq_datapath.sv
rtl/ordered_priority_queue_top.sv
bench/ordered_priority_queue_top_tb.sv
